// File: src/cmfuv_pkg.sv
// Shared types, constants and helpers for the cube map face / UV unit.
// No dependencies; every other file imports this package.
package cmfuv_pkg;

	// default direction component width (signed, Q1.14 at 16 bits)
	localparam int COORD_BITS_DEF = 16;

	// fraction bits of the Q1.16 texture coordinates
	localparam int FRAC_BITS = 16;
	// quotient width: one integer bit plus the fraction
	localparam int QW = FRAC_BITS + 1;
	// one step per quotient bit
	localparam int DIV_STEPS = QW;
	// 1.0 in Q1.16
	localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		FACE_PLUS_Y  = 3'd0,
		FACE_MINUS_X = 3'd1,
		FACE_MINUS_Y = 3'd2,
		FACE_PLUS_X  = 3'd3,
		FACE_PLUS_Z  = 3'd4,
		FACE_MINUS_Z = 3'd5
	} face_t;

	// per-item sideband that rides along the divider
	typedef struct packed {
		face_t face;
		logic  zero;
	} side_t;

	// tile column of a face in the 4x3 cross
	function automatic logic [1:0] tile_col(face_t f);
		logic [1:0] col;
		case (f)
			FACE_PLUS_X:  col = 2'd0;
			FACE_MINUS_Y: col = 2'd1;
			FACE_MINUS_X: col = 2'd2;
			FACE_PLUS_Y:  col = 2'd3;
			default:      col = 2'd2;
		endcase
		return col;
	endfunction

	// tile row of a face in the 4x3 cross
	function automatic logic [1:0] tile_row(face_t f);
		logic [1:0] row;
		case (f)
			FACE_PLUS_Z:  row = 2'd0;
			FACE_MINUS_Z: row = 2'd2;
			default:      row = 2'd1;
		endcase
		return row;
	endfunction

endpackage

// File: src/cmfuv_if.sv
// Valid/ready channel interfaces: direction input and face/UV result.
// Depends on cmfuv_pkg.
interface cmfuv_dir_if #(
	parameter int COORD_BITS = cmfuv_pkg::COORD_BITS_DEF
);
	import cmfuv_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] dir_x;
	logic signed [COORD_BITS-1:0] dir_y;
	logic signed [COORD_BITS-1:0] dir_z;

	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmfuv_uv_if;
	import cmfuv_pkg::*;

	logic          valid;
	logic          ready;
	face_t         face;
	logic [QW-1:0] tex_u;
	logic [QW-1:0] tex_v;
	logic          zero_error;

	modport source (output valid, face, tex_u, tex_v, zero_error, input ready);
	modport sink   (input valid, face, tex_u, tex_v, zero_error, output ready);
endinterface

// File: src/cmfuv_select.sv
// Front end: face selection (stage 1) and numerator/divisor build (stage 2).
// Depends on cmfuv_pkg.
module cmfuv_select #(
	parameter int COORD_BITS = cmfuv_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cmfuv_pkg::side_t             out_side,
	output logic [COORD_BITS+2:0]        num_u,
	output logic [COORD_BITS+2:0]        den_u,
	output logic [COORD_BITS+2:0]        num_v,
	output logic [COORD_BITS+2:0]        den_v
);
	import cmfuv_pkg::*;

	localparam int W = COORD_BITS + 3;

	// stage 1 combinational
	logic [COORD_BITS-1:0]        ax, ay, az;
	logic                         x_gt_y, x_gt_z, y_gt_z;
	face_t                        face_c;
	logic [COORD_BITS-1:0]        m_c;
	logic signed [COORD_BITS-1:0] ru_c, rv_c;

	// stage 1 registers
	logic                         valid_s1;
	logic                         ready_s1;
	face_t                        face_s1;
	logic                         zero_s1;
	logic [COORD_BITS-1:0]        m_s1;
	logic signed [COORD_BITS-1:0] ru_s1, rv_s1;

	// stage 2 combinational
	logic [W-1:0] m_w, ru_w, rv_w, nu_c, nv_c;
	logic [1:0]   tc, tr;

	// stage 2 registers
	logic         valid_s2;
	logic         ready_s2;
	side_t        side_s2;
	logic [W-1:0] nu_s2, nv_s2, du_s2, dv_s2;

	// magnitudes; the most negative value maps to 2^(COORD_BITS-1) unsigned
	always_comb begin
		ax = dir_x[COORD_BITS-1] ? (~dir_x + 1'b1) : dir_x;
		ay = dir_y[COORD_BITS-1] ? (~dir_y + 1'b1) : dir_y;
		az = dir_z[COORD_BITS-1] ? (~dir_z + 1'b1) : dir_z;
		x_gt_y = ax > ay;
		x_gt_z = ax > az;
		y_gt_z = ay > az;
	end

	// strict compares: ties fall through to Y, then Z
	always_comb begin
		if (x_gt_y && x_gt_z) begin
			m_c    = ax;
			ru_c   = dir_y;
			rv_c   = dir_z;
			face_c = dir_x[COORD_BITS-1] ? FACE_MINUS_X : FACE_PLUS_X;
		end else if (!x_gt_y && y_gt_z) begin
			m_c    = ay;
			ru_c   = dir_x;
			rv_c   = dir_z;
			face_c = dir_y[COORD_BITS-1] ? FACE_MINUS_Y : FACE_PLUS_Y;
		end else begin
			m_c    = az;
			ru_c   = dir_x;
			rv_c   = dir_y;
			face_c = dir_z[COORD_BITS-1] ? FACE_MINUS_Z : FACE_PLUS_Z;
		end
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			face_s1 <= face_c;
			zero_s1 <= (m_c == '0);
			m_s1    <= m_c;
			ru_s1   <= ru_c;
			rv_s1   <= rv_c;
		end
	end

	// u = (ru + m + 2*m*col) / 8m, v = (rv + m + 2*m*row) / 6m
	always_comb begin
		m_w  = W'(m_s1);
		ru_w = W'(ru_s1);
		rv_w = W'(rv_s1);
		tc   = tile_col(face_s1);
		tr   = tile_row(face_s1);
		nu_c = ru_w + m_w + (tc[0] ? (m_w << 1) : '0) + (tc[1] ? (m_w << 2) : '0);
		nv_c = rv_w + m_w + (tr[0] ? (m_w << 1) : '0) + (tr[1] ? (m_w << 2) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			side_s2.face <= face_s1;
			side_s2.zero <= zero_s1;
			nu_s2        <= nu_c;
			nv_s2        <= nv_c;
			du_s2        <= m_w << 3;
			dv_s2        <= (m_w << 2) + (m_w << 1);
		end
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign num_u     = nu_s2;
	assign den_u     = du_s2;
	assign num_v     = nv_s2;
	assign den_v     = dv_s2;

	// the minor component never exceeds the major, so the quotient stays <= 1
	a_num_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !side_s2.zero |-> nu_s2 <= du_s2 && nv_s2 <= dv_s2)
		else $error("numerator exceeds divisor");

endmodule

// File: src/cmfuv_div_step.sv
// One restoring-division step for both u and v, with its pipeline register.
// Depends on cmfuv_pkg.
module cmfuv_div_step #(
	parameter int COORD_BITS = cmfuv_pkg::COORD_BITS_DEF,
	// 0 for the integer bit (no shift), 1 for a fraction bit
	parameter bit SHIFT = 1'b1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cmfuv_pkg::side_t           in_side,
	input  logic [COORD_BITS+2:0]      in_rem_u,
	input  logic [COORD_BITS+2:0]      in_den_u,
	input  logic [cmfuv_pkg::QW-1:0]   in_quo_u,
	input  logic [COORD_BITS+2:0]      in_rem_v,
	input  logic [COORD_BITS+2:0]      in_den_v,
	input  logic [cmfuv_pkg::QW-1:0]   in_quo_v,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cmfuv_pkg::side_t           out_side,
	output logic [COORD_BITS+2:0]      out_rem_u,
	output logic [COORD_BITS+2:0]      out_den_u,
	output logic [cmfuv_pkg::QW-1:0]   out_quo_u,
	output logic [COORD_BITS+2:0]      out_rem_v,
	output logic [COORD_BITS+2:0]      out_den_v,
	output logic [cmfuv_pkg::QW-1:0]   out_quo_v
);
	import cmfuv_pkg::*;

	localparam int W = COORD_BITS + 3;

	logic [W:0]    trial_u, trial_v, diff_u, diff_v;
	logic          ge_u, ge_v;

	logic          valid_q;
	side_t         side_q;
	logic [W-1:0]  rem_u_q, den_u_q, rem_v_q, den_v_q;
	logic [QW-1:0] quo_u_q, quo_v_q;

	always_comb begin
		trial_u = SHIFT ? {in_rem_u, 1'b0} : {1'b0, in_rem_u};
		trial_v = SHIFT ? {in_rem_v, 1'b0} : {1'b0, in_rem_v};
		ge_u    = trial_u >= {1'b0, in_den_u};
		ge_v    = trial_v >= {1'b0, in_den_v};
		diff_u  = ge_u ? (trial_u - {1'b0, in_den_u}) : trial_u;
		diff_v  = ge_v ? (trial_v - {1'b0, in_den_v}) : trial_v;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// remainder stays below the divisor, so the top bit drops
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_q  <= in_side;
			rem_u_q <= diff_u[W-1:0];
			rem_v_q <= diff_v[W-1:0];
			den_u_q <= in_den_u;
			den_v_q <= in_den_v;
			quo_u_q <= {in_quo_u[QW-2:0], ge_u};
			quo_v_q <= {in_quo_v[QW-2:0], ge_v};
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_rem_u = rem_u_q;
	assign out_den_u = den_u_q;
	assign out_quo_u = quo_u_q;
	assign out_rem_v = rem_v_q;
	assign out_den_v = den_v_q;
	assign out_quo_v = quo_v_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !side_q.zero |-> rem_u_q < den_u_q && rem_v_q < den_v_q)
		else $error("partial remainder not below divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(quo_u_q) && $stable(quo_v_q))
		else $error("stalled step lost its quotient");

endmodule

// File: src/cmfuv_round.sv
// Final half-up rounding, zero-vector handling and the output register.
// Depends on cmfuv_pkg and cmfuv_uv_if.
module cmfuv_round #(
	parameter int COORD_BITS = cmfuv_pkg::COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  cmfuv_pkg::side_t         in_side,
	input  logic [COORD_BITS+2:0]    in_rem_u,
	input  logic [COORD_BITS+2:0]    in_den_u,
	input  logic [cmfuv_pkg::QW-1:0] in_quo_u,
	input  logic [COORD_BITS+2:0]    in_rem_v,
	input  logic [COORD_BITS+2:0]    in_den_v,
	input  logic [cmfuv_pkg::QW-1:0] in_quo_v,
	cmfuv_uv_if.source               uv
);
	import cmfuv_pkg::*;

	localparam int W = COORD_BITS + 3;

	logic [W:0]    sum_u, sum_v;
	logic          up_u, up_v;
	logic [QW-1:0] tex_u_c, tex_v_c;

	logic          valid_q;
	face_t         face_q;
	logic [QW-1:0] tex_u_q, tex_v_q;
	logic          zero_q;

	// divisors are even; adding half of one decides the rounding carry
	always_comb begin
		sum_u   = {1'b0, in_rem_u} + {2'b0, in_den_u[W-1:1]};
		sum_v   = {1'b0, in_rem_v} + {2'b0, in_den_v[W-1:1]};
		up_u    = sum_u >= {1'b0, in_den_u};
		up_v    = sum_v >= {1'b0, in_den_v};
		tex_u_c = in_side.zero ? '0 : (in_quo_u + QW'(up_u));
		tex_v_c = in_side.zero ? '0 : (in_quo_v + QW'(up_v));
	end

	assign in_ready = !valid_q || uv.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			face_q  <= in_side.face;
			zero_q  <= in_side.zero;
			tex_u_q <= tex_u_c;
			tex_v_q <= tex_v_c;
		end
	end

	assign uv.valid      = valid_q;
	assign uv.face       = face_q;
	assign uv.tex_u      = tex_u_q;
	assign uv.tex_v      = tex_v_q;
	assign uv.zero_error = zero_q;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && zero_q |-> tex_u_q == '0 && tex_v_q == '0 && face_q == FACE_PLUS_Z)
		else $error("zero vector result malformed");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !zero_q |-> tex_u_q <= QONE && tex_v_q <= QONE)
		else $error("texture coordinate above one");

endmodule

// File: src/cube_map_face_uv_unit.sv
// Top level of the cube map face / UV unit: select front end, divider steps,
// rounding stage. Depends on cmfuv_pkg, the channel interfaces and submodules.
//
// Takes one signed direction per cycle and returns the cube face of largest
// magnitude plus its UV in a 4x3 cross layout, unsigned Q1.16. Throughput is
// one item per clock while the output is ready. Each item passes the face
// selection and numerator build registers, one restoring-division step per
// quotient bit (a 17-bit quotient at the default), then the rounding stage into
// the output register. Each stage holds its item while the next one is full, so
// bubbles close up under backpressure and nothing is dropped. A zero vector
// gives face +Z, zero UV and zero_error set.
module cube_map_face_uv_unit #(
	parameter int COORD_BITS = cmfuv_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cmfuv_dir_if.sink  dir,
	cmfuv_uv_if.source uv
);
	import cmfuv_pkg::*;

	localparam int W = COORD_BITS + 3;

	logic          st_valid [0:DIV_STEPS];
	logic          st_ready [0:DIV_STEPS];
	side_t         st_side  [0:DIV_STEPS];
	logic [W-1:0]  st_rem_u [0:DIV_STEPS];
	logic [W-1:0]  st_den_u [0:DIV_STEPS];
	logic [QW-1:0] st_quo_u [0:DIV_STEPS];
	logic [W-1:0]  st_rem_v [0:DIV_STEPS];
	logic [W-1:0]  st_den_v [0:DIV_STEPS];
	logic [QW-1:0] st_quo_v [0:DIV_STEPS];

	cmfuv_select #(.COORD_BITS(COORD_BITS)) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dir.valid),
		.in_ready  (dir.ready),
		.dir_x     (dir.dir_x),
		.dir_y     (dir.dir_y),
		.dir_z     (dir.dir_z),
		.out_valid (st_valid[0]),
		.out_ready (st_ready[0]),
		.out_side  (st_side[0]),
		.num_u     (st_rem_u[0]),
		.den_u     (st_den_u[0]),
		.num_v     (st_rem_v[0]),
		.den_v     (st_den_v[0])
	);

	assign st_quo_u[0] = '0;
	assign st_quo_v[0] = '0;

	// first step yields the integer bit, the rest one fraction bit each
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		cmfuv_div_step #(
			.COORD_BITS (COORD_BITS),
			.SHIFT      (i != 0)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[i]),
			.in_ready  (st_ready[i]),
			.in_side   (st_side[i]),
			.in_rem_u  (st_rem_u[i]),
			.in_den_u  (st_den_u[i]),
			.in_quo_u  (st_quo_u[i]),
			.in_rem_v  (st_rem_v[i]),
			.in_den_v  (st_den_v[i]),
			.in_quo_v  (st_quo_v[i]),
			.out_valid (st_valid[i+1]),
			.out_ready (st_ready[i+1]),
			.out_side  (st_side[i+1]),
			.out_rem_u (st_rem_u[i+1]),
			.out_den_u (st_den_u[i+1]),
			.out_quo_u (st_quo_u[i+1]),
			.out_rem_v (st_rem_v[i+1]),
			.out_den_v (st_den_v[i+1]),
			.out_quo_v (st_quo_v[i+1])
		);
	end

	cmfuv_round #(.COORD_BITS(COORD_BITS)) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (st_valid[DIV_STEPS]),
		.in_ready (st_ready[DIV_STEPS]),
		.in_side  (st_side[DIV_STEPS]),
		.in_rem_u (st_rem_u[DIV_STEPS]),
		.in_den_u (st_den_u[DIV_STEPS]),
		.in_quo_u (st_quo_u[DIV_STEPS]),
		.in_rem_v (st_rem_v[DIV_STEPS]),
		.in_den_v (st_den_v[DIV_STEPS]),
		.in_quo_v (st_quo_v[DIV_STEPS]),
		.uv       (uv)
	);

endmodule

// File: tb/sv/cube_map_face_uv_unit_tb.sv
// Self-checking bench for cube_map_face_uv_unit: directed and random directions,
// predicted face and cross-layout UV compared per transfer with random stalls.
// Depends on cmfuv_pkg, the channel interfaces and the unit under test.
module cube_map_face_uv_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmfuv_pkg::*;

	localparam int     CB          = COORD_BITS_DEF;
	localparam int     DIR_MAX     = (1 << (CB - 1)) - 1;
	localparam int     DIR_MIN     = -(1 << (CB - 1));
	localparam int     N_RANDOM    = 650;
	localparam int     HOLD_CYCLES = 150;
	localparam int     CYCLE_LIMIT = 500000;
	localparam longint ONE_Q       = longint'(1) << FRAC_BITS;

	typedef logic signed [CB-1:0] dir_t;

	typedef struct {
		dir_t x, y, z;
		bit   drain;      // hold input until every result is back
	} dir_item_t;

	typedef struct {
		dir_t          dx, dy, dz;
		face_t         face;
		logic [QW-1:0] u, v;
		logic          zero;
	} uv_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmfuv_dir_if #(.COORD_BITS(CB)) dir_ch ();
	cmfuv_uv_if                     uv_ch ();

	cube_map_face_uv_unit #(.COORD_BITS(CB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.dir    (dir_ch),
		.uv     (uv_ch)
	);

	dir_item_t dir_backlog [$];
	uv_exp_t   expected_uv [$];

	int  n_directed  = 0;
	int  n_accepted  = 0;
	int  n_results   = 0;
	int  n_fail      = 0;
	int  n_zero      = 0;
	int  face_hits [6];
	int  cycle_cnt   = 0;
	int  send_gap    = 0;
	int  recv_gap    = 0;
	bit  send_calm   = 1'b0;
	bit  recv_calm   = 1'b0;
	int  hold_left   = 0;
	bit  hold_done   = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len(int idle_pct);
		int p;
		p = $urandom_range(0, 99);
		if (p >= idle_pct)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 70)
			return $urandom_range(1, 3);
		if (p < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic dir_t signed_of(int mag, bit neg);
		if (mag > DIR_MAX)
			return dir_t'(DIR_MIN);
		return neg ? dir_t'(-mag) : dir_t'(mag);
	endfunction

	function automatic uv_exp_t predict_uv(dir_t x, dir_t y, dir_t z);
		longint  ax, ay, az, m, ru, rv, col, row;
		uv_exp_t r;
		ax = (x < 0) ? -longint'(x) : longint'(x);
		ay = (y < 0) ? -longint'(y) : longint'(y);
		az = (z < 0) ? -longint'(z) : longint'(z);
		r.dx = x;
		r.dy = y;
		r.dz = z;
		// strict compares: ties fall through to Y, then Z
		if (ax > ay && ax > az) begin
			m = ax; ru = longint'(y); rv = longint'(z);
			r.face = (x < 0) ? FACE_MINUS_X : FACE_PLUS_X;
		end else if (ay > az) begin
			m = ay; ru = longint'(x); rv = longint'(z);
			r.face = (y < 0) ? FACE_MINUS_Y : FACE_PLUS_Y;
		end else begin
			m = az; ru = longint'(x); rv = longint'(y);
			r.face = (z < 0) ? FACE_MINUS_Z : FACE_PLUS_Z;
		end
		case (r.face)
			FACE_PLUS_X: begin
				col = 0; row = 1;
			end
			FACE_MINUS_X: begin
				col = 2; row = 1;
			end
			FACE_PLUS_Y: begin
				col = 3; row = 1;
			end
			FACE_MINUS_Y: begin
				col = 1; row = 1;
			end
			FACE_PLUS_Z: begin
				col = 2; row = 0;
			end
			default: begin
				col = 2; row = 2;
			end
		endcase
		if (m == 0) begin
			r.u    = '0;
			r.v    = '0;
			r.zero = 1'b1;
		end else begin
			// exact quotient, rounded once, halves up
			r.u    = QW'(((ru + m + 2 * m * col) * ONE_Q + 4 * m) / (8 * m));
			r.v    = QW'(((rv + m + 2 * m * row) * ONE_Q + 3 * m) / (6 * m));
			r.zero = 1'b0;
		end
		return r;
	endfunction

	task automatic queue_dir(int x, int y, int z);
		dir_item_t it;
		it.x     = dir_t'(x);
		it.y     = dir_t'(y);
		it.z     = dir_t'(z);
		it.drain = 1'b0;
		dir_backlog.insert(dir_backlog.size(), it);
	endtask

	task automatic queue_drain();
		dir_item_t it;
		it.x     = '0;
		it.y     = '0;
		it.z     = '0;
		it.drain = 1'b1;
		dir_backlog.insert(dir_backlog.size(), it);
	endtask

	// input side: one transfer per handshake, valid held until taken
	always @(posedge clk) begin : drive
		dir_item_t nxt;
		logic      go;
		if (arst_n) begin
			if (dir_ch.valid && dir_ch.ready) begin
				expected_uv.insert(expected_uv.size(),
					predict_uv(dir_ch.dir_x, dir_ch.dir_y, dir_ch.dir_z));
				n_accepted++;
				send_gap = send_calm ? 0 : idle_len(40);
				if (n_accepted % 64 == 0)
					send_calm = ($urandom_range(0, 3) == 0);
			end
			if (!dir_ch.valid || dir_ch.ready) begin
				go = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else begin
					if (dir_backlog.size() > 0 && dir_backlog[0].drain && expected_uv.size() == 0)
						void'(dir_backlog.pop_front());
					if (dir_backlog.size() > 0 && !dir_backlog[0].drain) begin
						nxt = dir_backlog.pop_front();
						go  = 1'b1;
					end
				end
				dir_ch.valid <= go;
				if (go) begin
					dir_ch.dir_x <= nxt.x;
					dir_ch.dir_y <= nxt.y;
					dir_ch.dir_z <= nxt.z;
				end
			end
		end
	end

	// one long receiver hold-off once the pipe is busy, so input must stall
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_accepted >= 200) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// output side: check each transfer against the oldest prediction
	always @(posedge clk) begin : collect
		uv_exp_t want;
		if (arst_n) begin
			if (uv_ch.valid && uv_ch.ready) begin
				n_results++;
				if (uv_ch.face <= FACE_MINUS_Z)
					face_hits[int'(uv_ch.face)]++;
				if (uv_ch.zero_error === 1'b1)
					n_zero++;
				if (expected_uv.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("ERROR: result with nothing pending: face %0d u %0d v %0d z %0b",
							uv_ch.face, uv_ch.tex_u, uv_ch.tex_v, uv_ch.zero_error);
				end else begin
					want = expected_uv.pop_front();
					if (uv_ch.face !== want.face || uv_ch.tex_u !== want.u
							|| uv_ch.tex_v !== want.v || uv_ch.zero_error !== want.zero) begin
						n_fail++;
						if (n_fail <= 10)
							$display({"ERROR: dir (%0d,%0d,%0d): face %0d/%0d u %0d/%0d ",
								"v %0d/%0d zero %0b/%0b (expected/actual)"},
								want.dx, want.dy, want.dz, want.face, uv_ch.face,
								want.u, uv_ch.tex_u, want.v, uv_ch.tex_v,
								want.zero, uv_ch.zero_error);
					end
				end
				if (n_results % 64 == 0)
					recv_calm = ($urandom_range(0, 3) == 0);
			end
			if (hold_left > 0) begin
				uv_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				uv_ch.ready <= 1'b0;
			end else begin
				uv_ch.ready <= 1'b1;
				recv_gap = recv_calm ? 0 : idle_len(25);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results still pending",
				cycle_cnt, expected_uv.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int   kind;
		int   axis;
		int   mj;
		dir_t comp [3];
		dir_t corner_vals [6];

		dir_ch.valid = 1'b0;
		dir_ch.dir_x = '0;
		dir_ch.dir_y = '0;
		dir_ch.dir_z = '0;
		uv_ch.ready  = 1'b0;
		corner_vals  = '{dir_t'(DIR_MIN), dir_t'(DIR_MIN + 1), -1, 0, 1, dir_t'(DIR_MAX)};

		// zero vector, axis extremes, tie-breaking, minor at +/- major, tiny vectors
		queue_dir(0, 0, 0);
		queue_dir(DIR_MAX, 0, 0);
		queue_dir(DIR_MIN, 0, 0);
		queue_dir(0, DIR_MAX, 0);
		queue_dir(0, DIR_MIN, 0);
		queue_dir(0, 0, DIR_MAX);
		queue_dir(0, 0, DIR_MIN);
		queue_dir(100, 100, 5);
		queue_dir(-100, 100, 0);
		queue_dir(200, 3, -200);
		queue_dir(0, -300, 300);
		queue_dir(7, 7, 7);
		queue_dir(DIR_MIN, DIR_MIN, DIR_MIN);
		queue_dir(DIR_MIN, DIR_MIN, DIR_MAX);
		queue_dir(DIR_MAX, DIR_MIN, 0);
		queue_dir(1000, -999, 999);
		queue_dir(DIR_MIN, DIR_MAX, -DIR_MAX);
		queue_dir(DIR_MAX, DIR_MAX, DIR_MIN);
		queue_dir(1, 0, 0);
		queue_dir(0, 0, -1);
		queue_dir(-1, 1, -1);
		queue_dir(3, -1, 1);
		queue_dir(-5, 2, -3);
		n_directed = dir_backlog.size();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 380 || i == 560)
				queue_drain();
			kind = $urandom_range(0, 99);
			axis = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++)
				comp[k] = dir_t'($urandom);
			if (kind < 45) begin
				// raw bits
			end else if (kind < 65) begin
				mj = $urandom_range(1 << (CB - 2), 1 << (CB - 1));
				for (int k = 0; k < 3; k++)
					comp[k] = signed_of($urandom_range(0, mj), $urandom_range(0, 1));
				comp[axis] = signed_of(mj, $urandom_range(0, 1));
			end else if (kind < 80) begin
				// two axes share the largest magnitude
				mj = $urandom_range(0, 1 << (CB - 1));
				for (int k = 0; k < 3; k++)
					comp[k] = signed_of(mj, $urandom_range(0, 1));
				comp[axis] = signed_of($urandom_range(0, mj), $urandom_range(0, 1));
			end else if (kind < 92) begin
				for (int k = 0; k < 3; k++)
					comp[k] = dir_t'($urandom_range(0, 8) - 4);
			end else begin
				for (int k = 0; k < 3; k++)
					comp[k] = corner_vals[$urandom_range(0, 5)];
			end
			queue_dir(comp[0], comp[1], comp[2]);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (dir_backlog.size() != 0 || dir_ch.valid)
			@(posedge clk);
		while (expected_uv.size() != 0)
			@(posedge clk);
		repeat (DIV_STEPS + 3 + 10) @(posedge clk);

		$display("Checked %0d directions (%0d directed), %0d zero vectors, one %0d-cycle hold-off",
			n_results, n_directed, n_zero, HOLD_CYCLES);
		$display("Faces +Y -X -Y +X +Z -Z: %0d %0d %0d %0d %0d %0d, mismatches %0d",
			face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
			face_hits[5], n_fail);
		if (n_fail == 0 && expected_uv.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: cube_map_face_uv_unit.f
src/cmfuv_pkg.sv
src/cmfuv_if.sv
src/cmfuv_select.sv
src/cmfuv_div_step.sv
src/cmfuv_round.sv
src/cube_map_face_uv_unit.sv
tb/sv/cube_map_face_uv_unit_tb.sv
